// ===== design/nearest_resize_int8_quantize_macros.svh =====
// Assertion helpers for the checker of this block.
`ifndef NEAREST_RESIZE_INT8_QUANTIZE_MACROS_SVH
`define NEAREST_RESIZE_INT8_QUANTIZE_MACROS_SVH

// Property checked out of reset only.
`define NRQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("nrq check failed");

// Property checked on every edge, reset included.
`define NRQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("nrq check failed");

`endif

// ===== design/nrq_pkg.sv =====
`default_nettype none
package nrq_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 7;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 8;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 8'd1;

  // Source size after reset, before clamping.
  localparam logic [CFG_DATA_W-1:0] SRC_DIM_RST = 13'd72;

  // Offset removed from every channel to get int8.
  localparam logic [PIX_W-1:0] QUANT_OFFSET = 8'd128;

  typedef struct packed {
    logic               emit;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } sel_t;

endpackage
`default_nettype wire

// ===== design/nrq_if.sv =====
`default_nettype none
interface nrq_pix_if;
  logic                       valid;
  logic                       ready;
  logic [nrq_pkg::PIX_W-1:0]  red;
  logic [nrq_pkg::PIX_W-1:0]  green;
  logic [nrq_pkg::PIX_W-1:0]  blue;
  logic                       frame_start;

  modport source (output valid, output red, output green, output blue,
                  output frame_start, input ready);
  modport sink (input valid, input red, input green, input blue,
                input frame_start, output ready);
endinterface

interface nrq_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [nrq_pkg::PIX_W-1:0]  out_red;
  logic signed [nrq_pkg::PIX_W-1:0]  out_green;
  logic signed [nrq_pkg::PIX_W-1:0]  out_blue;
  logic [nrq_pkg::COORD_W-1:0]       out_col;
  logic [nrq_pkg::COORD_W-1:0]       out_row;
  logic                              frame_last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_col, output out_row, output frame_last, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_col, input out_row, input frame_last, output ready);
endinterface

interface nrq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [nrq_pkg::CFG_IDX_W-1:0]    index;
  logic [nrq_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/nearest_resize_int8_quantize.sv =====
// Nearest-neighbour downscaler to OUT_WIDTH x OUT_HEIGHT with int8 output. Source
// RGB888 pixels enter in raster order, one beat per clock while in_px.ready is
// high, frame_start on the first pixel of each frame. Destination pixel (dx, dy)
// takes source pixel (floor(dx*W/OUT_WIDTH), floor(dy*H/OUT_HEIGHT)), sent as
// each channel minus 128 with its coordinates and frame_last on the final one.
// src_width and src_height are clamped into [OUT_WIDTH, MAX_SRC_DIM] and
// [OUT_HEIGHT, MAX_SRC_DIM] on write; write them only while no pixel is in flight.
// Throughput is one pixel per clock while the output is not stalled, set by the
// accumulator update between the input register and the output register, from
// which result beats leave. out_px.ready reaches in_px.ready through logic.
// Pixels after the last destination row are taken and dropped until the next
// frame start. No initialisation pass after reset.
`default_nettype none
module nearest_resize_int8_quantize #(
  parameter int OUT_WIDTH   = 72,
  parameter int OUT_HEIGHT  = 72,
  parameter int MAX_SRC_DIM = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nrq_pix_if.sink     in_px,
  nrq_res_if.source   out_px,
  nrq_cfg_if.sink     cfg_wr
);

  localparam int OUT_MAX = (OUT_WIDTH > OUT_HEIGHT) ? OUT_WIDTH : OUT_HEIGHT;
  localparam int DIM_MAX = (MAX_SRC_DIM > OUT_MAX) ? MAX_SRC_DIM : OUT_MAX;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);
  localparam int ACC_W   = $clog2(DIM_MAX + OUT_WIDTH + OUT_HEIGHT);

  function automatic logic [DIM_W-1:0] clamp_dim(
    input logic [nrq_pkg::CFG_DATA_W-1:0] v,
    input int                             lo
  );
    int vi;
    int r;
    vi = int'(v);
    if (vi < lo) begin
      r = lo;
    end else if (vi > MAX_SRC_DIM) begin
      r = MAX_SRC_DIM;
    end else begin
      r = vi;
    end
    return DIM_W'(r);
  endfunction

  localparam logic [DIM_W-1:0] W_RST = clamp_dim(nrq_pkg::SRC_DIM_RST, OUT_WIDTH);
  localparam logic [DIM_W-1:0] H_RST = clamp_dim(nrq_pkg::SRC_DIM_RST, OUT_HEIGHT);

  logic [DIM_W-1:0] w_r;
  logic [DIM_W-1:0] h_r;

  logic                      s1_v_r;
  logic [nrq_pkg::PIX_W-1:0] s1_red_r, s1_green_r, s1_blue_r;
  logic                      s1_fs_r;
  logic                      adv;
  logic                      out_v_r, out_v_nxt;
  nrq_pkg::sel_t             sel;

  logic signed [nrq_pkg::PIX_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic [nrq_pkg::COORD_W-1:0]      out_col_r, out_row_r;
  logic                             out_last_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= W_RST;
      h_r <= H_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        nrq_pkg::REG_SRC_WIDTH:  w_r <= clamp_dim(cfg_wr.data, OUT_WIDTH);
        nrq_pkg::REG_SRC_HEIGHT: h_r <= clamp_dim(cfg_wr.data, OUT_HEIGHT);
        default: ;
      endcase
    end
  end

  // Stage one advances whenever the output register is free or draining.
  assign adv          = s1_v_r && (!out_v_r || out_px.ready);
  assign in_px.ready  = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_px.ready) begin
      s1_v_r <= in_px.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_px.ready && in_px.valid) begin
      s1_red_r   <= in_px.red;
      s1_green_r <= in_px.green;
      s1_blue_r  <= in_px.blue;
      s1_fs_r    <= in_px.frame_start;
    end
  end

  nrq_select #(
    .OUT_WIDTH  (OUT_WIDTH),
    .OUT_HEIGHT (OUT_HEIGHT),
    .DIM_W      (DIM_W),
    .ACC_W      (ACC_W)
  ) u_nrq_select (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .frame_start (s1_fs_r),
    .w           (w_r),
    .h           (h_r),
    .sel         (sel)
  );

  always_comb begin
    if (adv) begin
      out_v_nxt = sel.emit;
    end else begin
      out_v_nxt = out_v_r && !out_px.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && sel.emit) begin
      out_red_r   <= $signed(s1_red_r ^ nrq_pkg::QUANT_OFFSET);
      out_green_r <= $signed(s1_green_r ^ nrq_pkg::QUANT_OFFSET);
      out_blue_r  <= $signed(s1_blue_r ^ nrq_pkg::QUANT_OFFSET);
      out_col_r   <= sel.col;
      out_row_r   <= sel.row;
      out_last_r  <= sel.last;
    end
  end

  assign out_px.valid      = out_v_r;
  assign out_px.out_red    = out_red_r;
  assign out_px.out_green  = out_green_r;
  assign out_px.out_blue   = out_blue_r;
  assign out_px.out_col    = out_col_r;
  assign out_px.out_row    = out_row_r;
  assign out_px.frame_last = out_last_r;

endmodule
`default_nettype wire

// ===== design/nrq_select.sv =====
`default_nettype none
module nrq_select #(
  parameter int OUT_WIDTH  = 72,
  parameter int OUT_HEIGHT = 72,
  parameter int DIM_W      = 13,
  parameter int ACC_W      = 14
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic               frame_start,
  input  wire logic [DIM_W-1:0]   w,
  input  wire logic [DIM_W-1:0]   h,
  output nrq_pkg::sel_t           sel
);

  localparam int DCOL_W = $clog2(OUT_WIDTH + 1);
  localparam int DROW_W = $clog2(OUT_HEIGHT + 1);

  localparam logic [DCOL_W-1:0] OW_D   = DCOL_W'(OUT_WIDTH);
  localparam logic [DCOL_W-1:0] OW_D_L = DCOL_W'(OUT_WIDTH - 1);
  localparam logic [DROW_W-1:0] OH_D   = DROW_W'(OUT_HEIGHT);
  localparam logic [DROW_W-1:0] OH_D_L = DROW_W'(OUT_HEIGHT - 1);
  localparam logic [ACC_W-1:0]  OW_A   = ACC_W'(OUT_WIDTH);
  localparam logic [ACC_W-1:0]  OH_A   = ACC_W'(OUT_HEIGHT);

  logic [DIM_W-1:0]  src_col_r,   src_col_nxt;
  logic [DCOL_W-1:0] dst_col_r,   dst_col_nxt;
  logic [DROW_W-1:0] dst_row_r,   dst_row_nxt;
  logic [ACC_W-1:0]  col_accum_r, col_accum_nxt;
  logic [ACC_W-1:0]  row_accum_r, row_accum_nxt;
  logic              row_sel_r,   row_sel_nxt;

  logic [DIM_W-1:0]  c_scol;
  logic [DCOL_W-1:0] c_dcol;
  logic [DROW_W-1:0] c_drow;
  logic [ACC_W-1:0]  c_cacc;
  logic [ACC_W-1:0]  c_racc;
  logic              c_sel;
  logic              emit;
  logic [ACC_W-1:0]  cacc_add;
  logic [ACC_W-1:0]  racc_add;
  logic [DIM_W-1:0]  scol_inc;

  always_comb begin
    // A frame start restarts the counters before this pixel is judged.
    if (frame_start) begin
      c_scol = '0;
      c_dcol = '0;
      c_drow = '0;
      c_cacc = '0;
      c_racc = '0;
      c_sel  = 1'b1;
    end else begin
      c_scol = src_col_r;
      c_dcol = dst_col_r;
      c_drow = dst_row_r;
      c_cacc = col_accum_r;
      c_racc = row_accum_r;
      c_sel  = row_sel_r;
    end

    emit = c_sel && (c_dcol < OW_D) && (c_cacc < OW_A);

    sel.emit = emit;
    sel.col  = nrq_pkg::COORD_W'(c_dcol);
    sel.row  = nrq_pkg::COORD_W'(c_drow);
    sel.last = (c_drow == OH_D_L) && (c_dcol == OW_D_L);

    cacc_add      = emit ? c_cacc + ACC_W'(w) : c_cacc;
    dst_col_nxt   = emit ? c_dcol + DCOL_W'(1) : c_dcol;
    col_accum_nxt = (cacc_add >= OW_A) ? cacc_add - OW_A : '0;

    scol_inc      = c_scol + DIM_W'(1);
    src_col_nxt   = scol_inc;
    dst_row_nxt   = c_drow;
    row_accum_nxt = c_racc;
    row_sel_nxt   = c_sel;
    racc_add      = c_racc;

    // End of a source row: wrap the column side, step the row side.
    if (scol_inc >= w) begin
      src_col_nxt   = '0;
      dst_col_nxt   = '0;
      col_accum_nxt = '0;
      racc_add      = c_sel ? c_racc + ACC_W'(h) : c_racc;
      dst_row_nxt   = c_sel ? c_drow + DROW_W'(1) : c_drow;
      row_accum_nxt = (racc_add >= OH_A) ? racc_add - OH_A : '0;
      row_sel_nxt   = (dst_row_nxt < OH_D) && (row_accum_nxt < OH_A);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r   <= '0;
      dst_col_r   <= '0;
      dst_row_r   <= '0;
      col_accum_r <= '0;
      row_accum_r <= '0;
      row_sel_r   <= 1'b0;
    end else if (step) begin
      src_col_r   <= src_col_nxt;
      dst_col_r   <= dst_col_nxt;
      dst_row_r   <= dst_row_nxt;
      col_accum_r <= col_accum_nxt;
      row_accum_r <= row_accum_nxt;
      row_sel_r   <= row_sel_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/nrq_chk.sv =====
`default_nettype none
`include "nearest_resize_int8_quantize_macros.svh"
module nrq_chk #(
  parameter int OUT_WIDTH  = 72,
  parameter int OUT_HEIGHT = 72
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nrq_pix_if.sink     in_px,
  nrq_res_if.source   out_px
);

  localparam logic [nrq_pkg::COORD_W-1:0] LAST_COL = nrq_pkg::COORD_W'(OUT_WIDTH - 1);
  localparam logic [nrq_pkg::COORD_W-1:0] LAST_ROW = nrq_pkg::COORD_W'(OUT_HEIGHT - 1);

  // No result beat straight after a reset edge.
  `NRQ_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_px.valid)
  // Hold a stalled result beat.
  `NRQ_ASSERT(a_out_hold, clk, rst_n,
    out_px.valid && !out_px.ready |=> out_px.valid && $stable(out_px.out_col))
  // With the output register empty the input side must be ready for a beat.
  `NRQ_ASSERT(a_in_free, clk, rst_n, !out_px.valid |-> in_px.ready)
  // The final beat sits at the last destination corner.
  `NRQ_ASSERT(a_last_corner, clk, rst_n,
    out_px.valid && out_px.frame_last |->
      out_px.out_col == LAST_COL && out_px.out_row == LAST_ROW)

endmodule

bind nearest_resize_int8_quantize nrq_chk #(
  .OUT_WIDTH  (OUT_WIDTH),
  .OUT_HEIGHT (OUT_HEIGHT)
) u_nrq_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_px  (in_px),
  .out_px (out_px)
);
`default_nettype wire
